// ----- hdl/gbn_pkg.sv -----
package gbn_pkg;

    // Default sizing
    localparam int DEF_WINDOW       = 4;
    localparam int DEF_SEQ_SPACE    = 8;
    localparam int DEF_PAYLOAD_BITS = 64;

    // Input transaction kinds
    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // Result codes
    typedef enum logic [2:0] {
        RES_SENT         = 3'd0,
        RES_RETX         = 3'd1,
        RES_FULL         = 3'd2,
        RES_ACK_TAKEN    = 3'd3,
        RES_ACK_CORRUPT  = 3'd4,
        RES_ACK_RANGE    = 3'd5,
        RES_TIMEOUT_IDLE = 3'd6
    } res_kind_t;

    // Retransmission timer commands
    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] payload;
        logic [2:0]  ack_num;
        logic        ack_ok;
    } item_t;

    typedef struct packed {
        res_kind_t   result_kind;
        logic [2:0]  seq_num;
        logic [63:0] data_out;
        timer_cmd_t  timer_cmd;
        logic [2:0]  in_flight;
        logic        last;
    } result_t;

    // Controller state
    typedef enum logic {
        ST_IDLE,
        ST_RETX
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic retx;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic go_retx;
        logic retx_last;
    } stat_t;

endpackage

// ----- hdl/go_back_n_sender.sv -----
// Channel   Handshake                     Payload
// -------   ---------------------------   ----------------------
// command   start & !busy, accepted       item   (gbn_pkg::item_t)
// result    result_valid, one-cycle pulse result (gbn_pkg::result_t)
//
// Send and ack transactions: result registered in the cycle after acceptance,
// busy stays low, so one transaction per cycle.
// Timeout with packets outstanding: one retransmit result per cycle for each
// packet (1..window), paced by the single read port of the payload ring;
// busy is high during the burst; results pass the read and result registers.
// Reset (rst_n low, async) empties the window; the ring needs no clearing.
// The receiver cannot stall: every result_valid pulse is a delivered result.
module go_back_n_sender #(
    parameter int WINDOW       = gbn_pkg::DEF_WINDOW,
    parameter int SEQ_SPACE    = gbn_pkg::DEF_SEQ_SPACE,
    parameter int PAYLOAD_BITS = gbn_pkg::DEF_PAYLOAD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  gbn_pkg::item_t   item,
    output logic             result_valid,
    output gbn_pkg::result_t result
);
    import gbn_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // Sequencer
    gbn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Window state, payload ring and result register
    gbn_datapath #(
        .WINDOW       (WINDOW),
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- hdl/gbn_ctrl.sv -----
module gbn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  gbn_pkg::stat_t stat,
    output gbn_pkg::ctrl_t ctrl,
    output logic           busy
);
    import gbn_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && stat.go_retx)
                begin
                    state_next = ST_RETX;
                end
            end
            ST_RETX:
            begin
                if (stat.retx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl.load = 1'b0;
        ctrl.retx = 1'b0;
        busy      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = start;
            end
            ST_RETX:
            begin
                ctrl.retx = 1'b1;
                busy      = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- hdl/gbn_datapath.sv -----
module gbn_datapath #(
    parameter int WINDOW       = gbn_pkg::DEF_WINDOW,
    parameter int SEQ_SPACE    = gbn_pkg::DEF_SEQ_SPACE,
    parameter int PAYLOAD_BITS = gbn_pkg::DEF_PAYLOAD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gbn_pkg::item_t   item,
    input  gbn_pkg::ctrl_t   ctrl,
    output gbn_pkg::stat_t   stat,
    output logic             result_valid,
    output gbn_pkg::result_t result
);
    import gbn_pkg::*;

    // Usable window keeps full and empty distinct
    localparam int EFF_WIN = (WINDOW < SEQ_SPACE) ? WINDOW : (SEQ_SPACE - 1);
    localparam int SEQ_W   = $clog2(SEQ_SPACE);
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(EFF_WIN + 1);
    localparam int PW1     = PTR_W + 1;
    localparam int SW1     = SEQ_W + 1;
    localparam int NW      = SEQ_W + 2;

    logic [SEQ_W-1:0]        base_reg, base_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SEQ_W-1:0]        ret_seq_reg, ret_seq_next;
    logic [PTR_W-1:0]        ret_ptr_reg, ret_ptr_next;
    logic [CNT_W-1:0]        ret_cnt_reg, ret_cnt_next;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic [PAYLOAD_BITS-1:0] mem [WINDOW];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;
    logic [PAYLOAD_BITS-1:0] pay_data;
    logic [PTR_W-1:0]        rd_addr;
    logic [PTR_W-1:0]        wr_ptr;
    logic                    mem_we;

    logic [PW1-1:0]          wr_sum;
    logic [SW1-1:0]          seq_sum;
    logic [SEQ_W-1:0]        next_seq;
    logic [NW-1:0]           ack_sum;
    logic [NW-1:0]           ack_plus1;
    logic [NW-1:0]           rel_n;
    logic [SEQ_W-1:0]        ack_base;
    logic [PW1-1:0]          head_sum;
    logic [PTR_W-1:0]        ack_head;
    logic [CNT_W-1:0]        ack_count;
    logic                    ack_bad_num;
    logic                    ack_beyond;

    assign pay_data = item.payload[PAYLOAD_BITS-1:0];

    // Store slot and sequence number of the next new packet
    assign wr_sum   = PW1'(head_reg) + PW1'(count_reg);
    assign wr_ptr   = (wr_sum >= PW1'(WINDOW)) ? PTR_W'(wr_sum - PW1'(WINDOW))
                                               : PTR_W'(wr_sum);
    assign seq_sum  = SW1'(base_reg) + SW1'(count_reg);
    assign next_seq = (seq_sum >= SW1'(SEQ_SPACE)) ? SEQ_W'(seq_sum - SW1'(SEQ_SPACE))
                                                   : SEQ_W'(seq_sum);

    // Cumulative ack: entries released and the new base
    assign ack_bad_num = 32'(item.ack_num) >= 32'(SEQ_SPACE);
    assign ack_plus1   = NW'(item.ack_num) + NW'(1);
    assign ack_base    = (ack_plus1 == NW'(SEQ_SPACE)) ? '0 : SEQ_W'(ack_plus1);
    assign ack_sum     = NW'(ack_base) + NW'(SEQ_SPACE) - NW'(base_reg);
    assign rel_n       = (ack_sum >= NW'(SEQ_SPACE)) ? (ack_sum - NW'(SEQ_SPACE)) : ack_sum;
    assign ack_beyond  = 32'(rel_n) > 32'(count_reg);
    assign head_sum    = PW1'(head_reg) + PW1'(rel_n);
    assign ack_head    = (head_sum >= PW1'(WINDOW)) ? PTR_W'(head_sum - PW1'(WINDOW))
                                                    : PTR_W'(head_sum);
    assign ack_count   = count_reg - CNT_W'(rel_n);

    // Status to controller
    assign stat.go_retx   = (item.kind == KIND_TIMEOUT) && (count_reg != '0);
    assign stat.retx_last = (ret_cnt_reg + CNT_W'(1)) == count_reg;

    assign rd_addr = ctrl.retx ? ret_ptr_reg : head_reg;

    // Transaction processing
    always_comb
    begin
        base_next         = base_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        ret_seq_next      = ret_seq_reg;
        ret_ptr_next      = ret_ptr_reg;
        ret_cnt_next      = ret_cnt_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mem_we            = 1'b0;

        if (ctrl.load)
        begin
            result_next.seq_num   = '0;
            result_next.data_out  = '0;
            result_next.timer_cmd = TMR_NONE;
            result_next.in_flight = 3'(count_reg);
            result_next.last      = 1'b1;
            case (item.kind)
                KIND_SEND:
                begin
                    result_valid_next = 1'b1;
                    if (32'(count_reg) >= EFF_WIN)
                    begin
                        result_next.result_kind = RES_FULL;
                    end
                    else
                    begin
                        mem_we                  = 1'b1;
                        count_next              = count_reg + CNT_W'(1);
                        result_next.result_kind = RES_SENT;
                        result_next.seq_num     = 3'(next_seq);
                        result_next.data_out    = 64'(pay_data);
                        result_next.timer_cmd   = (count_reg == '0) ? TMR_START : TMR_NONE;
                        result_next.in_flight   = 3'(count_next);
                    end
                end
                KIND_ACK:
                begin
                    result_valid_next = 1'b1;
                    if (!item.ack_ok)
                    begin
                        result_next.result_kind = RES_ACK_CORRUPT;
                    end
                    else if (ack_bad_num || ack_beyond)
                    begin
                        result_next.result_kind = RES_ACK_RANGE;
                    end
                    else
                    begin
                        base_next               = ack_base;
                        head_next               = ack_head;
                        count_next              = ack_count;
                        result_next.result_kind = RES_ACK_TAKEN;
                        result_next.timer_cmd   = (ack_count == '0) ? TMR_STOP : TMR_RESTART;
                        result_next.in_flight   = 3'(ack_count);
                    end
                end
                KIND_TIMEOUT:
                begin
                    if (count_reg == '0)
                    begin
                        result_valid_next       = 1'b1;
                        result_next.result_kind = RES_TIMEOUT_IDLE;
                        result_next.timer_cmd   = TMR_STOP;
                    end
                    else
                    begin
                        // oldest slot is being read this cycle
                        ret_seq_next = base_reg;
                        ret_cnt_next = '0;
                        ret_ptr_next = (head_reg == PTR_W'(WINDOW - 1)) ? '0
                                                                        : head_reg + PTR_W'(1);
                    end
                end
                default:
                begin
                    result_valid_next = 1'b0;
                end
            endcase
        end
        else if (ctrl.retx)
        begin
            // one outstanding packet per cycle, oldest first
            result_valid_next       = 1'b1;
            result_next.result_kind = RES_RETX;
            result_next.seq_num     = 3'(ret_seq_reg);
            result_next.data_out    = 64'(rd_data_reg);
            result_next.timer_cmd   = (ret_cnt_reg == '0) ? TMR_RESTART : TMR_NONE;
            result_next.in_flight   = 3'(count_reg);
            result_next.last        = stat.retx_last;
            ret_cnt_next            = ret_cnt_reg + CNT_W'(1);
            ret_seq_next = (ret_seq_reg == SEQ_W'(SEQ_SPACE - 1)) ? '0
                                                                  : ret_seq_reg + SEQ_W'(1);
            ret_ptr_next = (ret_ptr_reg == PTR_W'(WINDOW - 1)) ? '0
                                                               : ret_ptr_reg + PTR_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg         <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            ret_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg         <= base_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            ret_cnt_reg      <= ret_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ret_seq_reg <= ret_seq_next;
        ret_ptr_reg <= ret_ptr_next;
        result_reg  <= result_next;
    end

    // Unacked payload ring
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr] <= pay_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Outstanding count never exceeds the usable window
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= EFF_WIN)
        else $error("outstanding count above window");

    // Retransmission leaves the window untouched
    a_retx_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.retx |=> ($stable(count_reg) && $stable(base_reg) && $stable(head_reg)))
        else $error("window moved during retransmission");

    // A result that is not the last one is followed by another retransmit step
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.last) |-> ctrl.retx)
        else $error("retransmit burst cut short");

    // Retransmit results report the current outstanding count
    a_retx_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.result_kind == RES_RETX))
            |-> (result_reg.in_flight == 3'(count_reg)))
        else $error("retransmit in_flight mismatch");

endmodule

// ----- dv/tb_go_back_n_sender.sv -----
`timescale 1ns / 100ps

module tb_go_back_n_sender;
    import gbn_pkg::*;

    localparam int WIN          = DEF_WINDOW;
    localparam int SEQ          = DEF_SEQ_SPACE;
    localparam int EFF_WIN      = (WIN < SEQ) ? WIN : SEQ - 1;
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_TAIL    = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // kind code the sender does not define; it must be dropped silently
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Mirror of the sender window plus the queue of results the DUT still owes
    class gbn_scoreboard;
        int unsigned win_base  = 0;
        int unsigned next_seq  = 0;
        int unsigned ring_head = 0;
        logic [63:0] ring [WIN];
        result_t     owed_results [$];
        int unsigned errors    = 0;

        function int unsigned in_flight();
            return (next_seq + SEQ - win_base) % SEQ;
        endfunction

        function void owe(res_kind_t rk, int unsigned seq, logic [63:0] data,
                          timer_cmd_t tc, int unsigned fl, bit is_last);
            result_t r;
            r.result_kind = rk;
            r.seq_num     = 3'(seq);
            r.data_out    = data;
            r.timer_cmd   = tc;
            r.in_flight   = 3'(fl);
            r.last        = is_last;
            owed_results.insert(owed_results.size(), r);
        endfunction

        // Advance the window for one accepted transaction
        function void note_item(item_t it);
            int unsigned fl;
            int unsigned n;
            fl = in_flight();
            case (it.kind)
                KIND_SEND:
                begin
                    if (fl >= EFF_WIN)
                    begin
                        owe(RES_FULL, 0, '0, TMR_NONE, fl, 1'b1);
                    end
                    else
                    begin
                        ring[(ring_head + fl) % WIN] = it.payload;
                        owe(RES_SENT, next_seq, it.payload,
                            (fl == 0) ? TMR_START : TMR_NONE, fl + 1, 1'b1);
                        next_seq = (next_seq + 1) % SEQ;
                    end
                end
                KIND_ACK:
                begin
                    n = (it.ack_num + 1 + SEQ - win_base) % SEQ;
                    if (!it.ack_ok)
                    begin
                        owe(RES_ACK_CORRUPT, 0, '0, TMR_NONE, fl, 1'b1);
                    end
                    else if (n > fl)
                    begin
                        owe(RES_ACK_RANGE, 0, '0, TMR_NONE, fl, 1'b1);
                    end
                    else
                    begin
                        win_base  = (it.ack_num + 1) % SEQ;
                        ring_head = (ring_head + n) % WIN;
                        fl        = fl - n;
                        owe(RES_ACK_TAKEN, 0, '0, (fl == 0) ? TMR_STOP : TMR_RESTART,
                            fl, 1'b1);
                    end
                end
                KIND_TIMEOUT:
                begin
                    if (fl == 0)
                    begin
                        owe(RES_TIMEOUT_IDLE, 0, '0, TMR_STOP, 0, 1'b1);
                    end
                    else
                    begin
                        // go back: resend everything outstanding, oldest first
                        for (int unsigned k = 0; k < fl; k++)
                        begin
                            owe(RES_RETX, (win_base + k) % SEQ, ring[(ring_head + k) % WIN],
                                (k == 0) ? TMR_RESTART : TMR_NONE, fl, k + 1 == fl);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void field_check(string fname, logic [63:0] want_v, logic [63:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", fname, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with none outstanding: kind %0d seq %0d",
                       got.result_kind, got.seq_num);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            field_check("result_kind", want.result_kind, got.result_kind);
            field_check("seq_num", want.seq_num, got.seq_num);
            field_check("data_out", want.data_out, got.data_out);
            field_check("timer_cmd", want.timer_cmd, got.timer_cmd);
            field_check("in_flight", want.in_flight, got.in_flight);
            field_check("last", want.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        result_valid;
    result_t     result;
    int unsigned cycle_count = 0;

    gbn_scoreboard sb = new;

    go_back_n_sender dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Result monitor; the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            sb.check_result(result);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_go_back_n_sender: done, errors");
            $finish;
        end
    end

    function automatic item_t make_item(logic [1:0] kind, logic [63:0] payload,
                                        logic [2:0] ack_num, logic ack_ok);
        item_t it;
        it.kind    = kind;
        it.payload = payload;
        it.ack_num = ack_num;
        it.ack_ok  = ack_ok;
        return it;
    endfunction

    // Present one transaction and hold it until the DUT takes it
    task automatic issue(item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_item(it);
    endtask

    task automatic pause(int unsigned n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Mostly well-formed traffic: sends, in-window cumulative acks, timeouts
    function automatic item_t random_item();
        int unsigned pick;
        int unsigned fl;
        item_t       it;
        pick       = $urandom_range(0, 99);
        fl         = sb.in_flight();
        it.payload = {$urandom, $urandom};
        it.ack_num = 3'($urandom_range(0, 7));
        it.ack_ok  = 1'($urandom_range(0, 1));
        if (pick < 42)
        begin
            it.kind = KIND_SEND;
        end
        else if (pick < 80)
        begin
            it.kind = KIND_ACK;
            if (pick < 68)
            begin
                it.ack_ok  = 1'b1;
                it.ack_num = 3'((sb.win_base + SEQ - 1 + $urandom_range(0, fl)) % SEQ);
            end
        end
        else if (pick < 96)
        begin
            it.kind = KIND_TIMEOUT;
        end
        else
        begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty window: idle timeout, duplicate ack, ack past the window, corrupt ack
        issue(make_item(KIND_TIMEOUT, '0, 3'd0, 1'b0));
        issue(make_item(KIND_ACK, '0, 3'd7, 1'b1));
        issue(make_item(KIND_ACK, '1, 3'd0, 1'b1));
        issue(make_item(KIND_ACK, '0, 3'd0, 1'b0));
        // fill the window with extreme payloads, then overflow it
        issue(make_item(KIND_SEND, 64'h0, 3'd7, 1'b1));
        issue(make_item(KIND_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0));
        issue(make_item(KIND_SEND, 64'h5555_5555_5555_5555, 3'd2, 1'b1));
        issue(make_item(KIND_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd5, 1'b0));
        issue(make_item(KIND_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0));
        // full retransmission burst
        issue(make_item(KIND_TIMEOUT, '1, 3'd7, 1'b1));
        issue(make_item(KIND_ACK, '0, 3'd1, 1'b1));
        issue(make_item(KIND_ACK, '0, 3'd1, 1'b1));
        issue(make_item(KIND_ACK, '0, 3'd5, 1'b1));
        issue(make_item(KIND_UNUSED, '1, 3'd7, 1'b1));
        issue(make_item(KIND_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0));
        issue(make_item(KIND_SEND, 64'h7FFF_FFFF_FFFF_FFFE, 3'd0, 1'b0));
        issue(make_item(KIND_SEND, 64'hDEAD_BEEF_CAFE_F00D, 3'd0, 1'b0));
        issue(make_item(KIND_ACK, '0, 3'd5, 1'b1));
        // sequence numbers wrap inside the window
        issue(make_item(KIND_SEND, 64'h1111_2222_3333_4444, 3'd0, 1'b0));
        issue(make_item(KIND_SEND, 64'h5555_6666_7777_8888, 3'd0, 1'b0));
        issue(make_item(KIND_SEND, 64'h9999_AAAA_BBBB_CCCC, 3'd0, 1'b0));
        issue(make_item(KIND_TIMEOUT, '0, 3'd0, 1'b0));
        issue(make_item(KIND_ACK, '0, 3'd0, 1'b0));
        issue(make_item(KIND_ACK, '0, 3'd0, 1'b1));

        // random traffic with sender gaps, calm tail at the end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
            begin
                pause($urandom_range(1, 11));
            end
            issue(random_item());
        end
        @(negedge clk);
        start <= 1'b0;

        // drain
        while (sb.owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.owed_results.size() == 0)
        begin
            $display("tb_go_back_n_sender: done, clean");
        end
        else
        begin
            $display("tb_go_back_n_sender: done, errors");
        end
        $finish;
    end

endmodule
